@@ hw/rtl/keyboard_report_change_detector_defines.svh @@
// ----------------------------------------------------------------------------
// Keyboard report change detector assertion macros
// Concurrent check helpers used by the RTL of the change detector.
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_REPORT_CHANGE_DETECTOR_DEFINES_SVH
`define KEYBOARD_REPORT_CHANGE_DETECTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KRCD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("keyboard report change detector check failed");

// The consequent must hold in the cycle after the antecedent.
`define KRCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("keyboard report change detector check failed");

`endif

@@ hw/rtl/krcd_pkg.sv @@
// ----------------------------------------------------------------------------
// Keyboard report change detector package
// Event codes and configuration defaults of the change detector.
// ----------------------------------------------------------------------------
`default_nettype none

package krcd_pkg;

  localparam int unsigned KeySlotsDefault = 3;
  localparam int unsigned CodeWidth       = 8;
  localparam int unsigned WordWidth       = 64;
  localparam int unsigned ErrorBit        = 63;
  localparam int unsigned FirstSlotBit    = 8;

  typedef enum logic [1:0] {
    KindRelease = 2'd0,
    KindPress   = 2'd1,
    KindDone    = 2'd2
  } event_kind_e;

endpackage

`default_nettype wire

@@ hw/rtl/keyboard_report_change_detector.sv @@
// The first event of a word moves from the pending set to the output register once that register can take it.
// A word with R releases and P presses yields R + P + 1 events, from 1 up to 2*KeySlots+1
// (7 with three slots); the single output register shows one event a cycle while out_ready_i is high.
// The next word is taken in the cycle its predecessor's last event moves to the output register.
// Reset clears the held-key list, sets the empty code to zero and drops all pending events.
// ----------------------------------------------------------------------------
// Keyboard report change detector
// Compares each poll response with the previously held keys and emits
// release, press and done events one word at a time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "keyboard_report_change_detector_defines.svh"

module keyboard_report_change_detector #(
  parameter int unsigned KeySlots = krcd_pkg::KeySlotsDefault
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                empty_code_we_i,
  input  wire logic [krcd_pkg::CodeWidth-1:0]      empty_code_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [krcd_pkg::WordWidth-1:0]      response_word_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [1:0]                               event_kind_o,
  output logic [krcd_pkg::CodeWidth-1:0]           key_code_o,
  output logic                                     link_error_o,
  output logic                                     last_of_run_o
);

  localparam int unsigned EvNum  = 2 * KeySlots + 1;
  localparam int unsigned DoneEv = 2 * KeySlots;
  localparam int unsigned CW     = krcd_pkg::CodeWidth;

  logic [CW-1:0]                empty_code_q;
  logic [KeySlots-1:0][CW-1:0]  held_code_q;
  logic [KeySlots-1:0]          held_vld_q, held_vld_d;

  logic [EvNum-1:0]             pend_q, pend_d;
  logic [EvNum-1:0][CW-1:0]     ev_code_q;
  logic                         err_q;

  logic                         out_valid_q, out_valid_d;
  krcd_pkg::event_kind_e        kind_q, kind_d;
  logic [CW-1:0]                code_q, code_d;
  logic                         lerr_q, lerr_d;
  logic                         last_q, last_d;

  logic [KeySlots-1:0][CW-1:0]  slot_code;
  logic [KeySlots-1:0]          slot_vld;
  logic [KeySlots-1:0]          rel_hit, prs_hit;
  logic [EvNum-1:0]             new_pend;
  logic [EvNum-1:0][CW-1:0]     new_code;

  logic [EvNum-1:0]             sel_oh;
  logic                         out_load, in_fire, pend_any, pend_one;

  // Slots are compared in place: the nonempty slots in slot order are the
  // compacted held-key list, so a valid mask stands in for the fill count.
  always_comb begin
    rel_hit = '0;
    prs_hit = '0;
    for (int i = 0; i < KeySlots; i++) begin
      slot_code[i] = response_word_i[krcd_pkg::FirstSlotBit + CW * i +: CW];
      slot_vld[i]  = (slot_code[i] != empty_code_q);
    end
    for (int i = 0; i < KeySlots; i++) begin
      for (int j = 0; j < KeySlots; j++) begin
        rel_hit[i] = rel_hit[i] | (slot_vld[j] && (slot_code[j] == held_code_q[i]));
        prs_hit[j] = prs_hit[j] | (held_vld_q[i] && (held_code_q[i] == slot_code[j]));
      end
    end
    for (int i = 0; i < KeySlots; i++) begin
      new_pend[i]            = held_vld_q[i] && !rel_hit[i];
      new_code[i]            = held_code_q[i];
      new_pend[KeySlots + i] = slot_vld[i] && !prs_hit[i];
      new_code[KeySlots + i] = slot_code[i];
    end
    new_pend[DoneEv] = 1'b1;
    new_code[DoneEv] = '0;
  end

  // Pending events leave lowest position first: releases, presses, done.
  assign sel_oh   = pend_q & ((~pend_q) + EvNum'(1));
  assign pend_any = (pend_q != '0);
  assign pend_one = pend_any && ((pend_q & (pend_q - EvNum'(1))) == '0);
  assign out_load = !out_valid_q || out_ready_i;
  assign in_ready_o = !pend_any || (out_load && pend_one);
  assign in_fire  = in_valid_i && in_ready_o;

  always_comb begin
    kind_d = krcd_pkg::KindDone;
    code_d = '0;
    for (int p = 0; p < EvNum; p++) begin
      if (sel_oh[p]) begin
        if (p < KeySlots) begin
          kind_d = krcd_pkg::KindRelease;
        end else if (p < DoneEv) begin
          kind_d = krcd_pkg::KindPress;
        end
      end
      code_d = code_d | ({CW{sel_oh[p]}} & ev_code_q[p]);
    end
    last_d = sel_oh[DoneEv];
    lerr_d = sel_oh[DoneEv] & err_q;

    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      pend_d      = pend_q & ~sel_oh;
      out_valid_d = pend_any;
    end
    if (in_fire) begin
      pend_d = new_pend;
    end
    held_vld_d = in_fire ? slot_vld : held_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_code_q <= '0;
      held_vld_q   <= '0;
      pend_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (empty_code_we_i) begin
        empty_code_q <= empty_code_i;
      end
      held_vld_q  <= held_vld_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      held_code_q <= slot_code;
      ev_code_q   <= new_code;
      err_q       <= response_word_i[krcd_pkg::ErrorBit];
    end
    if (out_load && pend_any) begin
      kind_q <= kind_d;
      code_q <= code_d;
      lerr_q <= lerr_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = kind_q;
  assign key_code_o    = code_q;
  assign link_error_o  = lerr_q;
  assign last_of_run_o = last_q;

  `KRCD_ASSERT_NEXT(a_accept_queues_done, in_fire, pend_q[DoneEv])
  `KRCD_ASSERT_NOW(a_done_follows_event, out_valid_o && !last_of_run_o, pend_q[DoneEv])
  `KRCD_ASSERT_NOW(a_ready_only_draining, in_ready_o && pend_any, out_load && pend_one)
  `KRCD_ASSERT_NOW(a_error_only_on_done, out_valid_o && link_error_o, last_of_run_o)

endmodule

`default_nettype wire

@@ sim/tb_keyboard_report_change_detector.sv @@
// ----------------------------------------------------------------------------
// Keyboard report change detector testbench
// Streams poll responses into the detector through a stalling valid/ready
// driver, predicts the release, press and done events of every word, and
// checks each event against that prediction as the receiver takes it.
// ----------------------------------------------------------------------------
module tb_keyboard_report_change_detector;

  localparam int unsigned Slots        = krcd_pkg::KeySlotsDefault;
  localparam int unsigned CodeWidth    = krcd_pkg::CodeWidth;
  localparam int unsigned WordWidth    = krcd_pkg::WordWidth;
  localparam int unsigned FirstSlotBit = krcd_pkg::FirstSlotBit;
  localparam int unsigned ErrorBit     = krcd_pkg::ErrorBit;
  localparam int unsigned QuietLimit   = 2000;

  typedef struct packed {
    krcd_pkg::event_kind_e kind;
    logic [CodeWidth-1:0]  code;
    logic                  link_err;
    logic                  last;
  } key_event_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 empty_code_we_i = 1'b0;
  logic [CodeWidth-1:0] empty_code_i    = '0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_ready_o;
  logic [WordWidth-1:0] response_word_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i     = 1'b0;
  logic [1:0]           event_kind_o;
  logic [CodeWidth-1:0] key_code_o;
  logic                 link_error_o;
  logic                 last_of_run_o;

  logic [WordWidth-1:0] poll_words[$];
  key_event_t           key_events_due[$];

  // Shadow of the detector state and its one register.
  logic [CodeWidth-1:0] held_list[Slots];
  int unsigned          held_len   = 0;
  logic [CodeWidth-1:0] empty_now  = '0;

  int unsigned send_gap     = 0;
  int unsigned recv_stall   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches   = 0;
  bit          calm         = 1'b0;

  keyboard_report_change_detector u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_code_we_i (empty_code_we_i),
    .empty_code_i    (empty_code_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .response_word_i (response_word_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .event_kind_o    (event_kind_o),
    .key_code_o      (key_code_o),
    .link_error_o    (link_error_o),
    .last_of_run_o   (last_of_run_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic bit in_list(input logic [CodeWidth-1:0] list[Slots],
                                 input int unsigned len, input logic [CodeWidth-1:0] code);
    for (int i = 0; i < len; i++) begin
      if (list[i] == code) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Releases in old-list order, then presses in new-list order, then done.
  function automatic void predict_key_events(input logic [WordWidth-1:0] word);
    logic [CodeWidth-1:0] fresh[Slots];
    int unsigned          fresh_len;
    logic [CodeWidth-1:0] code;
    fresh_len = 0;
    foreach (fresh[i]) fresh[i] = '0;
    for (int i = 0; i < Slots; i++) begin
      code = word[FirstSlotBit + CodeWidth*i +: CodeWidth];
      if (code != empty_now) begin
        fresh[fresh_len] = code;
        fresh_len++;
      end
    end
    for (int i = 0; i < held_len; i++) begin
      if (!in_list(fresh, fresh_len, held_list[i])) begin
        key_events_due.push_back('{kind: krcd_pkg::KindRelease, code: held_list[i],
                                   link_err: 1'b0, last: 1'b0});
      end
    end
    for (int i = 0; i < fresh_len; i++) begin
      if (!in_list(held_list, held_len, fresh[i])) begin
        key_events_due.push_back('{kind: krcd_pkg::KindPress, code: fresh[i],
                                   link_err: 1'b0, last: 1'b0});
      end
    end
    key_events_due.push_back('{kind: krcd_pkg::KindDone, code: '0, link_err: word[ErrorBit],
                               last: 1'b1});
    held_list = fresh;
    held_len  = fresh_len;
  endfunction

  // Random filler outside the key slots so that every bit of the word toggles.
  function automatic logic [WordWidth-1:0] key_word(input logic err,
                                                     input logic [CodeWidth-1:0] c0,
                                                     input logic [CodeWidth-1:0] c1,
                                                     input logic [CodeWidth-1:0] c2);
    logic [WordWidth-1:0] w;
    w = {$urandom, $urandom};
    w[ErrorBit] = err;
    w[FirstSlotBit +: 3*CodeWidth] = {c2, c1, c0};
    return w;
  endfunction

  // Mostly a small set of keys, so that keys stay held across polls.
  function automatic logic [CodeWidth-1:0] pick_code();
    logic [CodeWidth-1:0] pool[6] = '{8'h04, 8'h05, 8'h16, 8'h2C, 8'hE1, 8'h00};
    case ($urandom_range(0, 9))
      0, 1, 2: return empty_now;
      8, 9: return CodeWidth'($urandom);
      default: return pool[$urandom_range(0, 5)];
    endcase
  endfunction

  task automatic queue_random(input int count);
    for (int n = 0; n < count; n++) begin
      poll_words.push_back(key_word(1'($urandom_range(0, 1)), pick_code(), pick_code(),
                                    pick_code()));
    end
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (poll_words.size() != 0 || in_valid_i || key_events_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_empty_code(input logic [CodeWidth-1:0] value);
    empty_code_we_i <= 1'b1;
    empty_code_i    <= value;
    @(posedge clk_i);
    empty_code_we_i <= 1'b0;
    empty_now = value;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty code still at its reset value of zero.
    poll_words.push_back('0);
    // Every slot holds 0xFF with the link error set: one press per copy.
    poll_words.push_back('1);
    poll_words.push_back(64'h8000_0000_0000_0000);
    poll_words.push_back(key_word(1'b0, 8'h04, 8'h05, 8'h06));
    poll_words.push_back(key_word(1'b0, 8'h04, 8'h07, 8'h06));
    poll_words.push_back(key_word(1'b1, 8'h07, 8'h00, 8'h04));
    poll_words.push_back(key_word(1'b0, 8'h04, 8'h04, 8'h00));
    poll_words.push_back(key_word(1'b0, 8'h00, 8'h00, 8'h00));
    poll_words.push_back(key_word(1'b0, 8'h01, 8'h80, 8'hFE));
    // The same keys in a new slot order cause no release or press events, only done.
    poll_words.push_back(key_word(1'b0, 8'hFE, 8'h01, 8'h80));
    drain();

    write_empty_code(8'hFF);
    poll_words.push_back('1);
    poll_words.push_back('0);
    poll_words.push_back(key_word(1'b1, 8'hFF, 8'h00, 8'hFF));
    queue_random(50);
    drain();

    write_empty_code(CodeWidth'($urandom_range(1, 254)));
    queue_random(70);
    drain();

    calm = 1'b1;
    write_empty_code(8'h00);
    queue_random(70);
    drain();
    repeat (10) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("keyboard_report_change_detector: match");
    end else begin
      $display("keyboard_report_change_detector: mismatch");
    end
    $finish;
  end

  // Sender: a new word is loaded only once the current one is taken.
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_ready_o)) begin
      if (send_gap != 0 && !calm) begin
        send_gap   <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (poll_words.size() != 0) begin
        response_word_i <= poll_words.pop_front();
        in_valid_i      <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 19);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (recv_stall != 0 && !calm) begin
        recv_stall  <= recv_stall - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) recv_stall <= $urandom_range(1, 19);
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    key_event_t due;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predict_key_events(response_word_i);
      if (out_valid_o && out_ready_i) begin
        if (key_events_due.size() == 0) begin
          $error("event with none due: event_kind %0d, key_code %0h", event_kind_o,
                 key_code_o);
          mismatches++;
        end else begin
          due = key_events_due.pop_front();
          if (event_kind_o !== due.kind) begin
            $error("event_kind: expected %0d, actual %0d", due.kind, event_kind_o);
            mismatches++;
          end
          if (key_code_o !== due.code) begin
            $error("key_code: expected %0h, actual %0h", due.code, key_code_o);
            mismatches++;
          end
          if (link_error_o !== due.link_err) begin
            $error("link_error: expected %0b, actual %0b", due.link_err, link_error_o);
            mismatches++;
          end
          if (last_of_run_o !== due.last) begin
            $error("last_of_run: expected %0b, actual %0b", due.last, last_of_run_o);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        empty_code_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("keyboard_report_change_detector: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
